### rtl/core/rpd_pkg.sv
// shared types and constants for the radio packet deframer
package rpd_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int COUNT_W      = 9;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] HDR_COUNT  = COUNT_W'(HEADER_BYTES);

  // header byte positions
  localparam logic [COUNT_W-1:0] IDX_STATION = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] IDX_FLAG    = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] IDX_COMMAND = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] IDX_LENGTH  = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] IDX_TIME    = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] IDX_MAC     = COUNT_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECC_ON      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECC_OFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LEN_ERR = 2'd1;
  localparam logic [1:0] ST_ECC_ERR = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [7:0]  station_id;
    logic        ecc_enabled;
    logic [7:0]  command_code;
    logic [7:0]  declared_length;
    logic [31:0] unix_time;
    logic [31:0] mac_word;
  } result_beat_t;

endpackage

### rtl/core/rpd_if.sv
// valid/ready channel interfaces for frame bytes and results
interface rpd_in_if;
  import rpd_pkg::*;
  logic        valid;
  logic        ready;
  frame_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rpd_out_if;
  import rpd_pkg::*;
  logic         valid;
  logic         ready;
  result_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/radio_packet_deframer.sv
// radio packet deframer: header capture, payload pass-through, frame status
//
// frame_in takes one frame byte per beat, frame_end marks the last byte.
// the first 12 bytes are the header (station, ecc flag, command, payload
// length, big-endian time, big-endian mac). payload bytes leave on
// result_out with payload_valid set; the last byte of a frame gives a beat
// with done_res set, the status and the captured header fields.
// bytes that are neither payload nor last give no result beat.
// a result beat is registered and appears in the cycle after its byte is accepted.
// throughput: one byte per cycle, set by the single result register; a
// byte is taken whenever that register is empty or being emptied.
// when result_out stalls, frame_in ready drops until the held beat leaves.
// reset clears the frame state and the result register and loads the
// default configuration (on code 1, off code 0, padding 0, frame limit
// 255, payload limit 243). configuration writes go through cfg_we,
// cfg_index and cfg_data; the user must make them only while the block is idle, the block does not enforce it.
module radio_packet_deframer (
  input  logic                          clk,
  input  logic                          rst,
  rpd_in_if.sink                        frame_in,
  rpd_out_if.source                     result_out,
  input  logic                          cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpd_pkg::*;

  // configuration registers
  logic [7:0] ecc_on_code, ecc_off_code, padding_code;
  logic [7:0] max_frame_length, max_payload_length;

  // frame state
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]  station_reg, station_next;
  logic [7:0]  flag_reg, flag_next;
  logic [7:0]  command_reg, command_next;
  logic [7:0]  length_reg, length_next;
  logic [31:0] time_reg, time_next;
  logic [31:0] mac_reg, mac_next;
  logic        bad_padding, bad_padding_next;

  // result register
  logic         out_valid;
  result_beat_t out_data;
  result_beat_t res_next;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [COUNT_W-1:0] frame_end_idx;
  logic        pvalid;
  logic [1:0]  st;

  assign frame_in.ready   = !out_valid || result_out.ready;
  assign accept           = frame_in.valid && frame_in.ready;
  assign b                = frame_in.data.frame_byte;
  assign last             = frame_in.data.frame_end;
  assign result_out.valid = out_valid;
  assign result_out.data  = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ecc_on_code        <= 8'd1;
      ecc_off_code       <= 8'd0;
      padding_code       <= 8'd0;
      max_frame_length   <= 8'd255;
      max_payload_length <= 8'd243;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ECC_ON:      ecc_on_code        <= cfg_data;
        REG_ECC_OFF:     ecc_off_code       <= cfg_data;
        REG_PADDING:     padding_code       <= cfg_data;
        REG_MAX_FRAME:   max_frame_length   <= cfg_data;
        REG_MAX_PAYLOAD: max_payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // header capture and payload/padding classification
  always_comb begin
    station_next     = station_reg;
    flag_next        = flag_reg;
    command_next     = command_reg;
    length_next      = length_reg;
    time_next        = time_reg;
    mac_next         = mac_reg;
    bad_padding_next = bad_padding;
    pvalid           = 1'b0;

    if (byte_count == IDX_STATION) begin
      station_next = b;
    end else if (byte_count == IDX_FLAG) begin
      flag_next = b;
    end else if (byte_count == IDX_COMMAND) begin
      command_next = b;
    end else if (byte_count == IDX_LENGTH) begin
      length_next = b;
    end else if (byte_count < IDX_MAC) begin
      time_next = {time_reg[23:0], b};
    end else if (byte_count < HDR_COUNT) begin
      mac_next = {mac_reg[23:0], b};
    end

    frame_end_idx = HDR_COUNT + {1'b0, length_next};
    if (byte_count >= HDR_COUNT) begin
      if (byte_count < frame_end_idx) begin
        pvalid = 1'b1;
      end else if (b != padding_code) begin
        bad_padding_next = 1'b1;
      end
    end

    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 1'b1 : COUNT_MAX;
  end

  // final status, checked in priority order
  always_comb begin
    if (byte_count_next < HDR_COUNT || byte_count_next > {1'b0, max_frame_length}) begin
      st = ST_LEN_ERR;
    end else if (flag_next != ecc_on_code && flag_next != ecc_off_code) begin
      st = ST_ECC_ERR;
    end else if (bad_padding_next) begin
      st = ST_LEN_ERR;
    end else if (length_next > max_payload_length || byte_count_next < frame_end_idx) begin
      st = ST_LEN_ERR;
    end else begin
      st = ST_OK;
    end
  end

  // result beat contents
  always_comb begin
    res_next               = '0;
    res_next.payload_byte  = pvalid ? b : 8'd0;
    res_next.payload_valid = pvalid;
    if (last) begin
      res_next.done_res        = 1'b1;
      res_next.status          = st;
      res_next.station_id      = station_next;
      res_next.ecc_enabled     = (flag_next == ecc_on_code);
      res_next.command_code    = command_next;
      res_next.declared_length = length_next;
      res_next.unix_time       = time_next;
      res_next.mac_word        = mac_next;
    end
  end

  // frame state update, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      station_reg <= '0;
      flag_reg    <= '0;
      command_reg <= '0;
      length_reg  <= '0;
      time_reg    <= '0;
      mac_reg     <= '0;
      bad_padding <= 1'b0;
    end else if (accept) begin
      if (last) begin
        byte_count  <= '0;
        station_reg <= '0;
        flag_reg    <= '0;
        command_reg <= '0;
        length_reg  <= '0;
        time_reg    <= '0;
        mac_reg     <= '0;
        bad_padding <= 1'b0;
      end else begin
        byte_count  <= byte_count_next;
        station_reg <= station_next;
        flag_reg    <= flag_next;
        command_reg <= command_next;
        length_reg  <= length_next;
        time_reg    <= time_next;
        mac_reg     <= mac_next;
        bad_padding <= bad_padding_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= pvalid || last;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

  // checks
  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (byte_count == '0))
    else $error("byte count not cleared after last byte");

  a_beat_has_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.payload_valid || out_data.done_res))
    else $error("result beat with neither payload nor done");

  a_header_zero_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.done_res) |->
      (out_data.status == ST_OK && out_data.station_id == 8'd0 &&
       out_data.unix_time == 32'd0 && out_data.mac_word == 32'd0))
    else $error("header fields set on a non-final beat");

  a_no_payload_in_header: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_count < HDR_COUNT) |-> !pvalid)
    else $error("header byte passed as payload");

endmodule

### sim/tb_top.sv
// testbench for the radio packet deframer: directed and random frames against a predictor
`timescale 1ns / 100ps

module tb_top;
  import rpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int BYTES_PER_PHASE = 150;
  localparam int MAX_REPORTS    = 40;

  typedef logic [7:0] byte_q_t [$];

  typedef enum {
    FR_CLEAN,
    FR_BAD_FLAG,
    FR_ODD_LENGTH,
    FR_BAD_PAD,
    FR_TRUNCATED,
    FR_NOISE
  } frame_kind_e;

  // tracks the frame state and the configuration, predicts result beats
  class frame_tracker;
    logic [7:0]         ecc_on, ecc_off, pad_code, max_frame, max_payload;
    logic [COUNT_W-1:0] next_pos;
    logic [7:0]         station, flag, command, length;
    logic [31:0]        stamp, mac;
    bit                 pad_broken;
    result_beat_t       awaited [$];
    int                 errors;

    function new();
      ecc_on      = 8'd1;
      ecc_off     = 8'd0;
      pad_code    = 8'd0;
      max_frame   = 8'd255;
      max_payload = 8'd243;
      errors      = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      next_pos   = '0;
      station    = '0;
      flag       = '0;
      command    = '0;
      length     = '0;
      stamp      = '0;
      mac        = '0;
      pad_broken = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      case (idx)
        REG_ECC_ON:      ecc_on = value;
        REG_ECC_OFF:     ecc_off = value;
        REG_PADDING:     pad_code = value;
        REG_MAX_FRAME:   max_frame = value;
        REG_MAX_PAYLOAD: max_payload = value;
        default: ;
      endcase
    endfunction

    // note an accepted frame byte and queue the beat it causes, if any
    function void take_frame_byte(frame_beat_t beat);
      logic [COUNT_W-1:0] pos;
      logic [COUNT_W-1:0] body_end;
      logic [COUNT_W-1:0] frame_len;
      logic [7:0]         b;
      bit                 carries_payload;
      result_beat_t       r;
      pos = next_pos;
      b = beat.frame_byte;
      carries_payload = 1'b0;

      // header capture
      if (pos == IDX_STATION) station = b;
      else if (pos == IDX_FLAG) flag = b;
      else if (pos == IDX_COMMAND) command = b;
      else if (pos == IDX_LENGTH) length = b;
      else if (pos < IDX_MAC) stamp = {stamp[23:0], b};
      else if (pos < HDR_COUNT) mac = {mac[23:0], b};

      // payload or padding past the header
      body_end = HDR_COUNT + {1'b0, length};
      if (pos >= HDR_COUNT) begin
        if (pos < body_end) carries_payload = 1'b1;
        else if (b != pad_code) pad_broken = 1'b1;
      end

      next_pos = (pos != COUNT_MAX) ? pos + 1'b1 : pos;
      if (!carries_payload && !beat.frame_end) return;

      r = '0;
      if (carries_payload) begin
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
      end
      // frame status on the last byte
      if (beat.frame_end) begin
        frame_len = next_pos;
        if (frame_len < HDR_COUNT || frame_len > {1'b0, max_frame}) r.status = ST_LEN_ERR;
        else if (flag != ecc_on && flag != ecc_off) r.status = ST_ECC_ERR;
        else if (pad_broken) r.status = ST_LEN_ERR;
        else if (length > max_payload || frame_len < body_end) r.status = ST_LEN_ERR;
        else r.status = ST_OK;
        r.done_res        = 1'b1;
        r.station_id      = station;
        r.ecc_enabled     = (flag == ecc_on);
        r.command_code    = command;
        r.declared_length = length;
        r.unix_time       = stamp;
        r.mac_word        = mac;
        clear_frame();
      end
      awaited.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    // check one accepted result beat against the oldest prediction
    function void check_result_beat(result_beat_t got);
      result_beat_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result beat, expected none, got 0x%0h", $time, got);
        return;
      end
      want = awaited.pop_front();
      compare("payload_byte", want.payload_byte, got.payload_byte);
      compare("payload_valid", want.payload_valid, got.payload_valid);
      compare("done_res", want.done_res, got.done_res);
      compare("status", want.status, got.status);
      compare("station_id", want.station_id, got.station_id);
      compare("ecc_enabled", want.ecc_enabled, got.ecc_enabled);
      compare("command_code", want.command_code, got.command_code);
      compare("declared_length", want.declared_length, got.declared_length);
      compare("unix_time", want.unix_time, got.unix_time);
      compare("mac_word", want.mac_word, got.mac_word);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rpd_in_if  frame_if ();
  rpd_out_if result_if ();

  frame_tracker tracker = new();
  int  bytes_sent = 0;
  bit  burst_mode = 1'b0;
  int  idle_cycles = 0;

  radio_packet_deframer dut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_if),
    .result_out (result_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic byte_q_t make_header(logic [7:0] station, logic [7:0] flag,
                                          logic [7:0] command, logic [7:0] length,
                                          logic [31:0] stamp, logic [31:0] mac);
    byte_q_t q;
    q = {station, flag, command, length,
         stamp[31:24], stamp[23:16], stamp[15:8], stamp[7:0],
         mac[31:24], mac[23:16], mac[15:8], mac[7:0]};
    return q;
  endfunction

  // one frame byte beat, followed by a random gap unless bursting
  task automatic send_beat(input frame_beat_t beat);
    int gap;
    frame_if.valid <= 1'b1;
    frame_if.data  <= beat;
    do @(posedge clk); while (!frame_if.ready);
    tracker.take_frame_byte(beat);
    bytes_sent++;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input byte_q_t q);
    frame_beat_t beat;
    foreach (q[i]) begin
      beat.frame_byte = q[i];
      beat.frame_end  = (i == q.size() - 1);
      send_beat(beat);
    end
  endtask

  // random frame: mostly well formed, the rest broken in one way or another
  task automatic send_random_frame();
    byte_q_t     q;
    frame_kind_e kind;
    int          roll, room, cap, body, deliver, pad_n, keep;
    logic [7:0]  flag;
    roll = $urandom_range(0, 99);
    if (roll < 65) kind = FR_CLEAN;
    else if (roll < 75) kind = FR_BAD_FLAG;
    else if (roll < 84) kind = FR_ODD_LENGTH;
    else if (roll < 91) kind = FR_BAD_PAD;
    else if (roll < 96) kind = FR_TRUNCATED;
    else kind = FR_NOISE;

    // payload size within the current limits, mostly small; odd-length frames declare any size
    room = int'(tracker.max_frame) - HEADER_BYTES;
    cap  = (room < int'(tracker.max_payload)) ? room : int'(tracker.max_payload);
    if ($urandom_range(0, 4) != 0) body = $urandom_range(0, (cap < 16) ? cap : 16);
    else body = $urandom_range(0, cap);
    if (kind == FR_ODD_LENGTH) body = $urandom_range(0, 255);
    deliver = (kind == FR_ODD_LENGTH) ? $urandom_range(0, body) : body;
    pad_n = room - deliver;
    if (pad_n > 4) pad_n = 4;
    if (pad_n < 0) pad_n = 0;
    pad_n = $urandom_range(0, pad_n);

    flag = $urandom_range(0, 1) ? tracker.ecc_on : tracker.ecc_off;
    if (kind == FR_BAD_FLAG) flag = 8'($urandom_range(0, 255));

    q = make_header(8'($urandom), flag, 8'($urandom), 8'(body), $urandom, $urandom);
    repeat (deliver) q.push_back(8'($urandom));
    repeat (pad_n) q.push_back(tracker.pad_code);

    // flip one bit of a padding byte, or append a wrong one
    if (kind == FR_BAD_PAD) begin
      if (pad_n == 0) q.push_back(tracker.pad_code ^ (8'h01 << $urandom_range(0, 7)));
      else q[q.size() - 1 - $urandom_range(0, pad_n - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end
    if (kind == FR_TRUNCATED) begin
      keep = $urandom_range(1, HEADER_BYTES - 1);
      while (q.size() > keep) void'(q.pop_back());
    end else if (kind == FR_NOISE) begin
      q.delete();
      repeat ($urandom_range(1, 300)) q.push_back(8'($urandom));
    end
    send_frame(q);
  endtask

  // stop sending and let every predicted beat come out
  task automatic wait_idle();
    frame_if.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] on_code, input logic [7:0] off_code,
                            input logic [7:0] pad, input logic [7:0] frame_max,
                            input logic [7:0] payload_max);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [7:0]           val [5];
    idx = '{REG_ECC_ON, REG_ECC_OFF, REG_PADDING, REG_MAX_FRAME, REG_MAX_PAYLOAD};
    val = '{on_code, off_code, pad, frame_max, payload_max};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      tracker.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: ready runs and stalls
  initial begin
    int run, gap;
    result_if.ready = 1'b0;
    forever begin
      run = $urandom_range(1, 40);
      result_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      tracker.check_result_beat(result_if.data);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** radio_packet_deframer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    byte_q_t    q;
    int         target;
    logic [7:0] on_code;
    rst            = 1'b1;
    frame_if.valid = 1'b0;
    frame_if.data  = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          // equal on and off codes, tightest limits
          1: write_regs(8'hFF, 8'hFF, 8'hFF, 8'd12, 8'd0);
          2: write_regs(8'h00, 8'hFF, 8'h00, 8'd255, 8'd243);
          3: write_regs(8'h00, 8'h00, 8'h80, 8'd40, 8'd20);
          default: begin
            on_code = 8'($urandom);
            write_regs(on_code, ($urandom_range(0, 3) == 0) ? on_code : 8'($urandom),
                       8'($urandom), 8'($urandom_range(12, 255)),
                       8'($urandom_range(0, 243)));
          end
        endcase
      end
      burst_mode = (phase % 3 == 2);

      // directed frames at the default settings
      if (phase == 0) begin
        q = {8'hFF};
        send_frame(q);
        q = make_header(8'h00, 8'h01, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
        send_frame(q);
        q = make_header(8'hFF, 8'h00, 8'h00, 8'h01, 32'h8000_0001, 32'hDEAD_BEEF);
        q.push_back(8'hFF);
        q.push_back(8'h00);
        send_frame(q);
        q = make_header(8'h5A, 8'h7E, 8'h81, 8'hFF, 32'h1234_5678, 32'hFFFF_FFFF);
        send_frame(q);
        // ends on a payload byte, short of the declared length
        q = make_header(8'hA5, 8'h01, 8'h42, 8'h02, 32'h0000_FFFF, 32'hFFFF_0000);
        q.push_back(8'h55);
        send_frame(q);
        // one byte short of a header
        q = make_header(8'h3C, 8'h00, 8'hC3, 8'h00, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        void'(q.pop_back());
        send_frame(q);
      end

      // frame long enough to saturate the byte counter
      if (phase == 1) begin
        q.delete();
        repeat (520) q.push_back(8'($urandom));
        send_frame(q);
      end

      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) send_random_frame();
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("** radio_packet_deframer: PASSED **");
    end else begin
      $display("** radio_packet_deframer: FAILED **");
    end
    $finish;
  end

endmodule
